// ===== hdl/ignition_power_mode_sequencer_defines.svh =====
// assertion macros for the ignition power mode sequencer
`ifndef IGNITION_POWER_MODE_SEQUENCER_DEFINES_SVH
`define IGNITION_POWER_MODE_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IPMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IPMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ipms_pkg.sv =====
// types and constants of the ignition power mode sequencer
`default_nettype none

package ipms_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    typedef logic [TIMER_WIDTH-1:0] t_timer;
    typedef logic [CMP_WIDTH-1:0]   t_cmp;
    typedef logic [2:0]             t_mode;

    localparam t_mode MODE_NORMAL   = 3'd0;
    localparam t_mode MODE_CHECK    = 3'd1;
    localparam t_mode MODE_PRESLEEP = 3'd2;
    localparam t_mode MODE_OFF      = 3'd3;
    localparam t_mode MODE_SLEEP    = 3'd4;

    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    localparam logic [2:0] REG_IGN_OFF_DELAY     = 3'd0;
    localparam logic [2:0] REG_BACKLIGHT_DELAY   = 3'd1;
    localparam logic [2:0] REG_CORE_BOOT_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_PRE_SLEEP_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_BUS_LOST_LIMIT    = 3'd4;

    localparam logic [7:0]  RST_IGN_OFF_DELAY     = 8'd200;
    localparam logic [9:0]  RST_BACKLIGHT_DELAY   = 10'd100;
    localparam logic [15:0] RST_CORE_BOOT_TIMEOUT = 16'd3000;
    localparam logic [15:0] RST_PRE_SLEEP_TIMEOUT = 16'd4000;
    localparam logic [15:0] RST_BUS_LOST_LIMIT    = 16'd500;

    typedef struct packed {
        logic hold_released;
        logic transceivers_on;
        logic pre_sleep_flag;
        logic power_down_request;
        logic buzzer_on;
        logic backlight_enable;
        logic core_power_on;
    } t_flags;

    localparam t_flags RST_FLAGS = '{transceivers_on: 1'b1, default: 1'b0};

    typedef struct packed {
        t_flags flags;
        t_mode  power_mode;
    } t_result;

    function automatic t_timer sat_inc(input t_timer t);
        return (t == '1) ? t : t_timer'(t + 1'b1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ignition_power_mode_sequencer.sv =====
// ignition power mode sequencer: tick-driven mode control with apb configuration
//
// One tick request is taken per clock cycle while s_axis_tready is high and yields
// exactly one result, written to the result register, or to the skid stage while
// that register holds an untaken one. The whole update of mode, counters and timers
// is one pass of logic between the state registers and the result register; the
// skid stage behind the result register lets a request be taken while a result
// still waits, so s_axis_tready only drops when both hold an untaken result.
// Timers saturate and are compared after incrementing. Registers: 0x00
// ignition-off delay, 0x04 backlight delay, 0x08 core boot timeout, 0x0c pre-sleep
// timeout, 0x10 bus lost limit; write them only while no tick is in flight.
`default_nettype none

`include "ignition_power_mode_sequencer_defines.svh"

module ignition_power_mode_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // ignition_on, door_open, backlight_ready, unit_activated, core_started,
    // close_request, load_jumper, bus_lost_time[15:0], ignition_wake, bus_wake
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // power_mode[2:0], core_power_on, backlight_enable, buzzer_on,
    // power_down_request, pre_sleep_flag, transceivers_on, hold_released
    output logic [15:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [ipms_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [ipms_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [ipms_pkg::DATA_WIDTH-1:0]      prdata,
    output logic             pready
);

    // configuration
    logic [7:0]  r_ign_off_delay;
    logic [9:0]  r_backlight_delay;
    logic [15:0] r_core_boot_timeout;
    logic [15:0] r_pre_sleep_timeout;
    logic [15:0] r_bus_lost_limit;

    // sequencer state
    ipms_pkg::t_mode  r_cur_mode, n_cur_mode;
    ipms_pkg::t_mode  r_pend_mode, n_pend_mode;
    logic             r_ign_prev;
    logic [7:0]       r_ign_off_cnt, n_ign_off_cnt;
    logic             r_bl_active, n_bl_active;
    logic             r_boot_active, n_boot_active;
    ipms_pkg::t_timer r_bl_timer, n_bl_timer;
    ipms_pkg::t_timer r_boot_timer, n_boot_timer;
    ipms_pkg::t_timer r_ps_timer, n_ps_timer;
    ipms_pkg::t_flags r_flags, n_flags;

    // result and skid stages
    ipms_pkg::t_result r_out, r_skid, n_result;
    logic              r_out_valid, r_skid_valid;

    logic        in_fire, out_fire, cfg_write;
    logic        ign, door, bl_ready, activated, core_started, close_req, jumper;
    logic        ign_wake, bus_wake;
    logic [15:0] bus_lost_time;
    logic [7:0]  cnt_inc;
    ipms_pkg::t_mode enter_mode;

    assign ign           = s_axis_tdata[0];
    assign door          = s_axis_tdata[1];
    assign bl_ready      = s_axis_tdata[2];
    assign activated     = s_axis_tdata[3];
    assign core_started  = s_axis_tdata[4];
    assign close_req     = s_axis_tdata[5];
    assign jumper        = s_axis_tdata[6];
    assign bus_lost_time = s_axis_tdata[22:7];
    assign ign_wake      = s_axis_tdata[23];
    assign bus_wake      = s_axis_tdata[24];

    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[4:2])
            ipms_pkg::REG_IGN_OFF_DELAY:     prdata = {24'b0, r_ign_off_delay};
            ipms_pkg::REG_BACKLIGHT_DELAY:   prdata = {22'b0, r_backlight_delay};
            ipms_pkg::REG_CORE_BOOT_TIMEOUT: prdata = {16'b0, r_core_boot_timeout};
            ipms_pkg::REG_PRE_SLEEP_TIMEOUT: prdata = {16'b0, r_pre_sleep_timeout};
            ipms_pkg::REG_BUS_LOST_LIMIT:    prdata = {16'b0, r_bus_lost_limit};
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign_off_delay     <= ipms_pkg::RST_IGN_OFF_DELAY;
            r_backlight_delay   <= ipms_pkg::RST_BACKLIGHT_DELAY;
            r_core_boot_timeout <= ipms_pkg::RST_CORE_BOOT_TIMEOUT;
            r_pre_sleep_timeout <= ipms_pkg::RST_PRE_SLEEP_TIMEOUT;
            r_bus_lost_limit    <= ipms_pkg::RST_BUS_LOST_LIMIT;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                ipms_pkg::REG_IGN_OFF_DELAY:     r_ign_off_delay     <= pwdata[7:0];
                ipms_pkg::REG_BACKLIGHT_DELAY:   r_backlight_delay   <= pwdata[9:0];
                ipms_pkg::REG_CORE_BOOT_TIMEOUT: r_core_boot_timeout <= pwdata[15:0];
                ipms_pkg::REG_PRE_SLEEP_TIMEOUT: r_pre_sleep_timeout <= pwdata[15:0];
                ipms_pkg::REG_BUS_LOST_LIMIT:    r_bus_lost_limit    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // one tick of the sequencer
    always_comb begin
        n_cur_mode    = r_cur_mode;
        n_pend_mode   = r_pend_mode;
        n_bl_active   = r_bl_active;
        n_boot_active = r_boot_active;
        n_bl_timer    = r_bl_timer;
        n_boot_timer  = r_boot_timer;
        n_ps_timer    = r_ps_timer;
        n_flags       = r_flags;
        enter_mode    = ipms_pkg::MODE_OFF;

        // ignition-off count, clamped to the delay
        cnt_inc = (r_ign_off_cnt != 8'hff) ? 8'(r_ign_off_cnt + 1'b1) : r_ign_off_cnt;
        if (!r_ign_prev) begin
            n_ign_off_cnt = (cnt_inc >= r_ign_off_delay) ? r_ign_off_delay : cnt_inc;
        end else begin
            n_ign_off_cnt = '0;
        end

        if (r_cur_mode == r_pend_mode) begin
            unique case (r_cur_mode)
                ipms_pkg::MODE_NORMAL: begin
                    if (!ign && n_ign_off_cnt >= r_ign_off_delay) begin
                        n_pend_mode = ipms_pkg::MODE_PRESLEEP;
                    end
                end
                ipms_pkg::MODE_CHECK: begin
                    if (r_bl_active) n_bl_timer = ipms_pkg::sat_inc(r_bl_timer);
                    if (r_boot_active) n_boot_timer = ipms_pkg::sat_inc(r_boot_timer);
                    if (r_bl_active && ipms_pkg::t_cmp'(n_bl_timer)
                            >= ipms_pkg::t_cmp'(r_backlight_delay)) begin
                        n_bl_active              = 1'b0;
                        n_flags.backlight_enable = 1'b1;
                    end
                    if (bl_ready) begin
                        if (!activated) begin
                            n_pend_mode = ipms_pkg::MODE_NORMAL;
                        end else if (r_boot_active) begin
                            if (ipms_pkg::t_cmp'(n_boot_timer)
                                    >= ipms_pkg::t_cmp'(r_core_boot_timeout)) begin
                                n_boot_timer = '0;
                                if (jumper) n_pend_mode = ipms_pkg::MODE_OFF;
                            end else if (core_started) begin
                                n_boot_active = 1'b0;
                                n_pend_mode   = ipms_pkg::MODE_NORMAL;
                            end
                        end
                    end
                end
                ipms_pkg::MODE_PRESLEEP: begin
                    n_ps_timer = ipms_pkg::sat_inc(r_ps_timer);
                    if (ign) begin
                        n_pend_mode = ipms_pkg::MODE_NORMAL;
                    end else begin
                        if (close_req || ipms_pkg::t_cmp'(n_ps_timer)
                                >= ipms_pkg::t_cmp'(r_pre_sleep_timeout)) begin
                            n_pend_mode = ipms_pkg::MODE_OFF;
                        end
                        if (door) n_ps_timer = '0;
                    end
                end
                ipms_pkg::MODE_OFF: begin
                    if (ign || door) begin
                        n_pend_mode = ipms_pkg::MODE_CHECK;
                    end else if (bus_lost_time > r_bus_lost_limit) begin
                        n_pend_mode = ipms_pkg::MODE_SLEEP;
                    end
                end
                ipms_pkg::MODE_SLEEP: begin
                    if (ign_wake || bus_wake) begin
                        n_flags.hold_released = 1'b0;
                        n_pend_mode           = ipms_pkg::MODE_OFF;
                    end else begin
                        n_flags.hold_released = 1'b1;
                    end
                end
                default: begin
                    n_cur_mode  = ipms_pkg::MODE_OFF;
                    n_pend_mode = ipms_pkg::MODE_OFF;
                end
            endcase
        end else begin
            // leave actions of the old mode
            unique case (r_cur_mode)
                ipms_pkg::MODE_CHECK: begin
                    n_bl_active   = 1'b0;
                    n_boot_active = 1'b0;
                end
                ipms_pkg::MODE_PRESLEEP: n_flags.pre_sleep_flag = 1'b0;
                ipms_pkg::MODE_SLEEP: begin
                    n_ign_off_cnt           = '0;
                    n_flags.transceivers_on = 1'b1;
                    n_flags.hold_released   = 1'b0;
                end
                default: ;
            endcase

            enter_mode  = (r_pend_mode <= ipms_pkg::MODE_SLEEP) ? r_pend_mode
                                                               : ipms_pkg::MODE_OFF;
            n_cur_mode  = enter_mode;
            n_pend_mode = enter_mode;

            // enter actions of the new mode
            unique case (enter_mode)
                ipms_pkg::MODE_CHECK: begin
                    n_flags.core_power_on      = 1'b1;
                    n_flags.power_down_request = 1'b0;
                    n_flags.buzzer_on          = 1'b1;
                    n_boot_active              = 1'b1;
                    n_boot_timer               = '0;
                    n_bl_active                = 1'b1;
                    n_bl_timer                 = '0;
                end
                ipms_pkg::MODE_PRESLEEP: begin
                    n_flags.pre_sleep_flag     = 1'b1;
                    n_flags.power_down_request = 1'b1;
                    n_ps_timer                 = '0;
                end
                ipms_pkg::MODE_OFF: begin
                    n_bl_active              = 1'b0;
                    n_flags.backlight_enable = 1'b0;
                    n_flags.core_power_on    = 1'b0;
                end
                ipms_pkg::MODE_SLEEP: begin
                    n_flags.transceivers_on = 1'b0;
                    n_flags.buzzer_on       = 1'b0;
                end
                default: ;
            endcase
        end

        n_result.power_mode = n_cur_mode;
        n_result.flags      = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mode    <= ipms_pkg::MODE_PRESLEEP;
            r_pend_mode   <= ipms_pkg::MODE_PRESLEEP;
            r_ign_prev    <= 1'b0;
            r_ign_off_cnt <= '0;
            r_bl_active   <= 1'b0;
            r_boot_active <= 1'b0;
            r_bl_timer    <= '0;
            r_boot_timer  <= '0;
            r_ps_timer    <= '0;
            r_flags       <= ipms_pkg::RST_FLAGS;
        end else if (in_fire) begin
            r_cur_mode    <= n_cur_mode;
            r_pend_mode   <= n_pend_mode;
            r_ign_prev    <= ign;
            r_ign_off_cnt <= n_ign_off_cnt;
            r_bl_active   <= n_bl_active;
            r_boot_active <= n_boot_active;
            r_bl_timer    <= n_bl_timer;
            r_boot_timer  <= n_boot_timer;
            r_ps_timer    <= n_ps_timer;
            r_flags       <= n_flags;
        end
    end

    // result register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!in_fire) begin
                r_out_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_result;
            end
        end else if (in_fire) begin
            if (r_out_valid) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    `IPMS_ASSERT_IMPL(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid stage holds a result with the output register empty")
    `IPMS_ASSERT_NEXT(a_stall_to_skid, in_fire && r_out_valid && !m_axis_tready,
        r_skid_valid, "request taken during a stall was not parked in the skid stage")
    `IPMS_ASSERT_IMPL(a_hold_only_sleep, r_flags.hold_released,
        r_cur_mode == ipms_pkg::MODE_SLEEP, "hold released outside sleep")
    `IPMS_ASSERT_IMPL(a_xcvr_off_only_sleep, !r_flags.transceivers_on,
        r_cur_mode == ipms_pkg::MODE_SLEEP, "transceivers off outside sleep")

endmodule

`default_nettype wire

// ===== test/tb_ignition_power_mode_sequencer.sv =====
// testbench of the ignition power mode sequencer: tick stream checked against a mode predictor
module tb_ignition_power_mode_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    // one tick request, packed as on s_axis_tdata (lowest field last)
    typedef struct packed {
        logic        bus_wake;
        logic        ign_wake;
        logic [15:0] bus_lost;
        logic        jumper;
        logic        close_req;
        logic        core_started;
        logic        activated;
        logic        bl_ready;
        logic        door;
        logic        ign;
    } t_tick;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PULSED, RX_SPARSE} t_rx_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // ignition_on, door_open, backlight_ready, unit_activated, core_started,
    // close_request, load_jumper, bus_lost_time[15:0], ignition_wake, bus_wake
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // power_mode[2:0], core_power_on, backlight_enable, buzzer_on,
    // power_down_request, pre_sleep_flag, transceivers_on, hold_released
    logic [15:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ipms_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [ipms_pkg::DATA_WIDTH-1:0] pwdata = '0;
    logic [ipms_pkg::DATA_WIDTH-1:0] prdata;
    logic        pready;

    ignition_power_mode_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    ipms_pkg::t_mode        mdl_mode;
    ipms_pkg::t_mode        mdl_next;
    logic                   mdl_ign_prev;
    logic [7:0]             mdl_off_cnt;
    logic                   mdl_bl_run;
    logic                   mdl_boot_run;
    ipms_pkg::t_timer       mdl_bl_timer;
    ipms_pkg::t_timer       mdl_boot_timer;
    ipms_pkg::t_timer       mdl_ps_timer;
    ipms_pkg::t_flags       mdl_flags;
    logic [7:0]             cfg_ign_off;
    logic [9:0]             cfg_bl;
    logic [15:0]            cfg_boot;
    logic [15:0]            cfg_ps;
    logic [15:0]            cfg_bus;

    ipms_pkg::t_result expected_status[$];
    int        mismatches = 0;
    int        ticks_sent = 0;
    int        results_checked = 0;
    int        reg_reads = 0;
    int        mode_hits[5] = '{default: 0};
    bit        ign_level = 1'b0;
    bit        holdoff_flip = 1'b0;
    bit        holdoff_seen = 1'b0;
    int        holdoff_left = 0;
    int        stall_left = 0;
    t_rx_style stall_style = RX_ALWAYS;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ignition_power_mode_sequencer verification failed");
        $finish;
    end

    function automatic ipms_pkg::t_timer timer_tick(input ipms_pkg::t_timer v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void advance_mode_model(input t_tick t);
        ipms_pkg::t_result r;
        if (!mdl_ign_prev) begin
            if (mdl_off_cnt != 8'hff) mdl_off_cnt = mdl_off_cnt + 1'b1;
            if (mdl_off_cnt >= cfg_ign_off) mdl_off_cnt = cfg_ign_off;
        end else begin
            mdl_off_cnt = '0;
        end
        mdl_ign_prev = t.ign;

        if (mdl_mode == mdl_next) begin
            case (mdl_mode)
                ipms_pkg::MODE_NORMAL: begin
                    if (!t.ign && mdl_off_cnt >= cfg_ign_off) mdl_next = ipms_pkg::MODE_PRESLEEP;
                end
                ipms_pkg::MODE_CHECK: begin
                    if (mdl_bl_run) mdl_bl_timer = timer_tick(mdl_bl_timer);
                    if (mdl_boot_run) mdl_boot_timer = timer_tick(mdl_boot_timer);
                    if (mdl_bl_run && mdl_bl_timer >= cfg_bl) begin
                        mdl_bl_run = 1'b0;
                        mdl_flags.backlight_enable = 1'b1;
                    end
                    if (t.bl_ready) begin
                        if (!t.activated) begin
                            mdl_next = ipms_pkg::MODE_NORMAL;
                        end else if (mdl_boot_run) begin
                            if (mdl_boot_timer >= cfg_boot) begin
                                mdl_boot_timer = '0;
                                if (t.jumper) mdl_next = ipms_pkg::MODE_OFF;
                            end else if (t.core_started) begin
                                mdl_boot_run = 1'b0;
                                mdl_next = ipms_pkg::MODE_NORMAL;
                            end
                        end
                    end
                end
                ipms_pkg::MODE_PRESLEEP: begin
                    mdl_ps_timer = timer_tick(mdl_ps_timer);
                    if (t.ign) begin
                        mdl_next = ipms_pkg::MODE_NORMAL;
                    end else begin
                        if (t.close_req || mdl_ps_timer >= cfg_ps) mdl_next = ipms_pkg::MODE_OFF;
                        if (t.door) mdl_ps_timer = '0;
                    end
                end
                ipms_pkg::MODE_OFF: begin
                    if (t.ign || t.door) mdl_next = ipms_pkg::MODE_CHECK;
                    else if (t.bus_lost > cfg_bus) mdl_next = ipms_pkg::MODE_SLEEP;
                end
                ipms_pkg::MODE_SLEEP: begin
                    if (t.ign_wake || t.bus_wake) begin
                        mdl_flags.hold_released = 1'b0;
                        mdl_next = ipms_pkg::MODE_OFF;
                    end else begin
                        mdl_flags.hold_released = 1'b1;
                    end
                end
                default: begin
                    mdl_mode = ipms_pkg::MODE_OFF;
                    mdl_next = ipms_pkg::MODE_OFF;
                end
            endcase
        end else begin
            case (mdl_mode)
                ipms_pkg::MODE_CHECK: begin
                    mdl_bl_run = 1'b0;
                    mdl_boot_run = 1'b0;
                end
                ipms_pkg::MODE_PRESLEEP: mdl_flags.pre_sleep_flag = 1'b0;
                ipms_pkg::MODE_SLEEP: begin
                    mdl_off_cnt = '0;
                    mdl_flags.transceivers_on = 1'b1;
                    mdl_flags.hold_released = 1'b0;
                end
                default: ;
            endcase
            mdl_mode = (mdl_next <= ipms_pkg::MODE_SLEEP) ? mdl_next : ipms_pkg::MODE_OFF;
            mdl_next = mdl_mode;
            case (mdl_mode)
                ipms_pkg::MODE_CHECK: begin
                    mdl_flags.core_power_on = 1'b1;
                    mdl_flags.power_down_request = 1'b0;
                    mdl_flags.buzzer_on = 1'b1;
                    mdl_boot_run = 1'b1;
                    mdl_boot_timer = '0;
                    mdl_bl_run = 1'b1;
                    mdl_bl_timer = '0;
                end
                ipms_pkg::MODE_PRESLEEP: begin
                    mdl_flags.pre_sleep_flag = 1'b1;
                    mdl_flags.power_down_request = 1'b1;
                    mdl_ps_timer = '0;
                end
                ipms_pkg::MODE_OFF: begin
                    mdl_bl_run = 1'b0;
                    mdl_flags.backlight_enable = 1'b0;
                    mdl_flags.core_power_on = 1'b0;
                end
                ipms_pkg::MODE_SLEEP: begin
                    mdl_flags.transceivers_on = 1'b0;
                    mdl_flags.buzzer_on = 1'b0;
                end
                default: ;
            endcase
        end
        r.power_mode = mdl_mode;
        r.flags = mdl_flags;
        expected_status.push_back(r);
    endfunction

    function automatic logic [31:0] model_register(input logic [2:0] idx);
        case (idx)
            ipms_pkg::REG_IGN_OFF_DELAY:     return 32'(cfg_ign_off);
            ipms_pkg::REG_BACKLIGHT_DELAY:   return 32'(cfg_bl);
            ipms_pkg::REG_CORE_BOOT_TIMEOUT: return 32'(cfg_boot);
            ipms_pkg::REG_PRE_SLEEP_TIMEOUT: return 32'(cfg_ps);
            ipms_pkg::REG_BUS_LOST_LIMIT:    return 32'(cfg_bus);
            default:                         return '0;
        endcase
    endfunction

    function automatic t_tick make_tick(input bit ign, input bit door, input bit blr,
                                        input bit act, input bit core, input bit close,
                                        input bit jmp, input logic [15:0] bus,
                                        input bit iw, input bit bw);
        t_tick t;
        t.ign = ign;
        t.door = door;
        t.bl_ready = blr;
        t.activated = act;
        t.core_started = core;
        t.close_req = close;
        t.jumper = jmp;
        t.bus_lost = bus;
        t.ign_wake = iw;
        t.bus_wake = bw;
        return t;
    endfunction

    // ignition held in runs, rare events, bus silence near the limit; some pure noise
    function automatic t_tick random_tick();
        t_tick t;
        int    bus;
        if ($urandom_range(0, 7) == 0) begin
            t = 25'($urandom());
            return t;
        end
        if ($urandom_range(0, 11) == 0) ign_level = ~ign_level;
        case ($urandom_range(0, 2))
            0:       bus = $urandom_range(0, 65535);
            1:       bus = $urandom_range(0, 60);
            default: bus = int'(cfg_bus) + int'($urandom_range(0, 2)) - 1;
        endcase
        if (bus < 0) bus = 0;
        if (bus > 65535) bus = 65535;
        t = make_tick(ign_level, $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) != 0, $urandom_range(0, 5) == 0,
                      $urandom_range(0, 11) == 0, 1'($urandom_range(0, 1)), bus[15:0],
                      $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        return t;
    endfunction

    task automatic send_tick(input t_tick t);
        s_axis_tdata <= {7'd0, t};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_mode_model(t);
        ticks_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_traffic(input int count, input bit with_gaps);
        int burst;
        burst = $urandom_range(1, 30);
        for (int n = 0; n < count; n++) begin
            send_tick(random_tick());
            burst--;
            if (with_gaps && burst == 0) begin
                pause_sender($urandom_range(1, 8));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_status.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ipms_pkg::REG_IGN_OFF_DELAY:     cfg_ign_off = value[7:0];
            ipms_pkg::REG_BACKLIGHT_DELAY:   cfg_bl = value[9:0];
            ipms_pkg::REG_CORE_BOOT_TIMEOUT: cfg_boot = value[15:0];
            ipms_pkg::REG_PRE_SLEEP_TIMEOUT: cfg_ps = value[15:0];
            ipms_pkg::REG_BUS_LOST_LIMIT:    cfg_bus = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic read_register(input logic [2:0] idx, output logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        reg_reads++;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input int ign_off, input int bl, input int boot,
                                input int ps, input int bus);
        write_register(ipms_pkg::REG_IGN_OFF_DELAY, ign_off);
        write_register(ipms_pkg::REG_BACKLIGHT_DELAY, bl);
        write_register(ipms_pkg::REG_CORE_BOOT_TIMEOUT, boot);
        write_register(ipms_pkg::REG_PRE_SLEEP_TIMEOUT, ps);
        write_register(ipms_pkg::REG_BUS_LOST_LIMIT, bus);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result checking
    always @(posedge i_clk) begin
        ipms_pkg::t_result want;
        ipms_pkg::t_flags  got_flags;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_flags = ipms_pkg::t_flags'(m_axis_tdata[9:3]);
            if (m_axis_tdata[2:0] <= ipms_pkg::MODE_SLEEP) mode_hits[m_axis_tdata[2:0]]++;
            if (expected_status.size() == 0) begin
                $display("%0t ns: result %h with no request pending, expected none",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_status.pop_front();
                check_field("power_mode", int'(want.power_mode), int'(m_axis_tdata[2:0]));
                check_field("core_power_on", int'(want.flags.core_power_on),
                            int'(got_flags.core_power_on));
                check_field("backlight_enable", int'(want.flags.backlight_enable),
                            int'(got_flags.backlight_enable));
                check_field("buzzer_on", int'(want.flags.buzzer_on),
                            int'(got_flags.buzzer_on));
                check_field("power_down_request", int'(want.flags.power_down_request),
                            int'(got_flags.power_down_request));
                check_field("pre_sleep_flag", int'(want.flags.pre_sleep_flag),
                            int'(got_flags.pre_sleep_flag));
                check_field("transceivers_on", int'(want.flags.transceivers_on),
                            int'(got_flags.transceivers_on));
                check_field("hold_released", int'(want.flags.hold_released),
                            int'(got_flags.hold_released));
            end
            results_checked++;
        end
    end

    // result side stalls, with a long hold-off on demand
    always @(posedge i_clk) begin
        if (holdoff_flip != holdoff_seen) begin
            holdoff_seen <= holdoff_flip;
            holdoff_left <= 120;
            m_axis_tready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_style <= t_rx_style'($urandom_range(0, 3));
                stall_left <= $urandom_range(30, 200);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_style)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PULSED: m_axis_tready <= stall_left[1];
                default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic test_register_access();
        logic [31:0] got;
        logic [2:0]  idx;
        for (int k = ipms_pkg::REG_IGN_OFF_DELAY; k <= ipms_pkg::REG_BUS_LOST_LIMIT; k++) begin
            idx = k[2:0];
            read_register(idx, got);
            check_field("register after reset", model_register(idx), got);
            write_register(idx, $urandom());
            read_register(idx, got);
            check_field("register readback", model_register(idx), got);
        end
    endtask

    task automatic test_directed_walk();
        apply_config(1, 1, 2, 2, 100);
        // pre-sleep closed by request, off, sleep on bus silence, wake
        send_tick(make_tick(0, 0, 0, 0, 0, 1, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'hffff, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 1, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        // door opens check; boot timeout without and then with jumper
        send_tick(make_tick(0, 1, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 1, 1, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 1, 1, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 1, 1, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 1, 1, 0, 0, 1, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        // ignition into check, core started, normal, ignition off into pre-sleep
        send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(1, 0, 1, 1, 1, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(0, 1, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0));
        settle_block();
    endtask

    task automatic test_config_extremes();
        apply_config(0, 0, 0, 0, 0);
        send_traffic(100, 1'b0);
        settle_block();
        apply_config(255, 1023, 65535, 65535, 65535);
        send_traffic(100, 1'b1);
        settle_block();
    endtask

    task automatic test_receiver_holdoff();
        apply_config(2, 3, 5, 4, 50);
        holdoff_flip = ~holdoff_flip;
        send_traffic(40, 1'b0);
        settle_block();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0)
                apply_config($urandom_range(0, 255), $urandom_range(0, 1023),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
            else
                apply_config($urandom_range(1, 12), $urandom_range(1, 20),
                             $urandom_range(1, 40), $urandom_range(1, 30),
                             $urandom_range(0, 2000));
            send_traffic(110, 1'b1);
            settle_block();
        end
    endtask

    initial begin
        mdl_mode = ipms_pkg::MODE_PRESLEEP;
        mdl_next = ipms_pkg::MODE_PRESLEEP;
        mdl_ign_prev = 1'b0;
        mdl_off_cnt = '0;
        mdl_bl_run = 1'b0;
        mdl_boot_run = 1'b0;
        mdl_bl_timer = '0;
        mdl_boot_timer = '0;
        mdl_ps_timer = '0;
        mdl_flags = ipms_pkg::RST_FLAGS;
        cfg_ign_off = ipms_pkg::RST_IGN_OFF_DELAY;
        cfg_bl = ipms_pkg::RST_BACKLIGHT_DELAY;
        cfg_boot = ipms_pkg::RST_CORE_BOOT_TIMEOUT;
        cfg_ps = ipms_pkg::RST_PRE_SLEEP_TIMEOUT;
        cfg_bus = ipms_pkg::RST_BUS_LOST_LIMIT;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_walk();
        test_config_extremes();
        test_receiver_holdoff();
        test_random_traffic();

        settle_block();
        repeat (4) @(posedge i_clk);
        $display("covered %0d ticks, %0d results and %0d register reads over 12 settings",
                 ticks_sent, results_checked, reg_reads);
        $display("results per mode normal/check/pre-sleep/off/sleep: %0d/%0d/%0d/%0d/%0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("ignition_power_mode_sequencer verification clean");
        end else begin
            $display("ignition_power_mode_sequencer verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ipms_pkg.sv
hdl/ignition_power_mode_sequencer.sv
test/tb_ignition_power_mode_sequencer.sv
